### sv/mtto_pkg.sv
package mtto_pkg;

	localparam int QDEPTH = 2;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'd32;
	localparam logic [7:0] HEX_GAP  = 8'd7;

	typedef struct packed {
		logic [23:0] text;
		logic [2:0]  len;
	} tok_t;

	function automatic logic [23:0] k1(input logic [7:0] a);
		return {a, 16'h0000};
	endfunction

	function automatic logic [23:0] k2(input logic [15:0] a);
		return {a, 8'h00};
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = c - "0";
		if (v > 8'd9) v = v - HEX_GAP;
		return v[3:0];
	endfunction

	// key holds first byte in the top bits, unused bytes zero
	function automatic logic [8:0] lookup(input logic [23:0] key);
		logic [8:0] r;
		r = 9'h000;
		case (key)
			k1("0"): r = {1'b1, 8'h00};
			k1("1"): r = {1'b1, 8'h01};
			k1("2"): r = {1'b1, 8'h02};
			k1("3"): r = {1'b1, 8'h03};
			k1("4"): r = {1'b1, 8'h04};
			k1("5"): r = {1'b1, 8'h05};
			k1("6"): r = {1'b1, 8'h06};
			k1("7"): r = {1'b1, 8'h07};
			k1("8"): r = {1'b1, 8'h08};
			k1("9"): r = {1'b1, 8'h09};
			k2("0A"): r = {1'b1, 8'h0A};
			k2("0B"): r = {1'b1, 8'h0B};
			k2("0C"): r = {1'b1, 8'h0C};
			k2("0D"): r = {1'b1, 8'h0D};
			k2("0E"): r = {1'b1, 8'h0E};
			k2("0F"): r = {1'b1, 8'h0F};
			k2("E'"): r = {1'b1, 8'h10};
			k1("A"): r = {1'b1, 8'h11};
			k1("B"): r = {1'b1, 8'h12};
			k1("C"): r = {1'b1, 8'h13};
			k1("D"): r = {1'b1, 8'h14};
			k1("E"): r = {1'b1, 8'h15};
			k2("A'"): r = {1'b1, 8'h16};
			k2("B'"): r = {1'b1, 8'h17};
			k2("C'"): r = {1'b1, 8'h18};
			k2("D'"): r = {1'b1, 8'h19};
			"A''": r = {1'b1, 8'h1A};
			"B''": r = {1'b1, 8'h1B};
			"C''": r = {1'b1, 8'h1C};
			"D''": r = {1'b1, 8'h1D};
			"E''": r = {1'b1, 8'h1E};
			k1("F"): r = {1'b1, 8'h1F};
			"2ND": r = {1'b1, 8'h21};
			"INV": r = {1'b1, 8'h22};
			"LNX": r = {1'b1, 8'h23};
			k2("CE"): r = {1'b1, 8'h24};
			"CLR": r = {1'b1, 8'h25};
			"SB*": r = {1'b1, 8'h26};
			"HI*": r = {1'b1, 8'h27};
			"LOG": r = {1'b1, 8'h28};
			k2("CP"): r = {1'b1, 8'h29};
			"COD": r = {1'b1, 8'h2B};
			"LG2": r = {1'b1, 8'h2C};
			"RND": r = {1'b1, 8'h2D};
			"TAN": r = {1'b1, 8'h30};
			"LRN": r = {1'b1, 8'h31};
			"X/T": r = {1'b1, 8'h32};
			k2("X2"): r = {1'b1, 8'h33};
			"SQR": r = {1'b1, 8'h34};
			"1/X": r = {1'b1, 8'h35};
			"PGM": r = {1'b1, 8'h36};
			"P/R": r = {1'b1, 8'h37};
			"SIN": r = {1'b1, 8'h38};
			"COS": r = {1'b1, 8'h39};
			"TMP": r = {1'b1, 8'h3A};
			"X/Y": r = {1'b1, 8'h3B};
			"SNH": r = {1'b1, 8'h3C};
			"CSH": r = {1'b1, 8'h3D};
			"TNH": r = {1'b1, 8'h3E};
			"IND": r = {1'b1, 8'h40};
			"SST": r = {1'b1, 8'h41};
			"STO": r = {1'b1, 8'h42};
			"RCL": r = {1'b1, 8'h43};
			"SUM": r = {1'b1, 8'h44};
			k2("YX"): r = {1'b1, 8'h45};
			"INS": r = {1'b1, 8'h46};
			"CMS": r = {1'b1, 8'h47};
			"EXC": r = {1'b1, 8'h48};
			"PRD": r = {1'b1, 8'h49};
			"BAT": r = {1'b1, 8'h4A};
			k2("N!"): r = {1'b1, 8'h4B};
			"LN!": r = {1'b1, 8'h4C};
			"LG!": r = {1'b1, 8'h4D};
			"MD2": r = {1'b1, 8'h4E};
			"IXI": r = {1'b1, 8'h50};
			"BST": r = {1'b1, 8'h51};
			k2("EE"): r = {1'b1, 8'h52};
			k1("("): r = {1'b1, 8'h53};
			k1(")"): r = {1'b1, 8'h54};
			k1("/"): r = {1'b1, 8'h55};
			"DEL": r = {1'b1, 8'h56};
			"ENG": r = {1'b1, 8'h57};
			"FIX": r = {1'b1, 8'h58};
			"INT": r = {1'b1, 8'h59};
			"LCD": r = {1'b1, 8'h5A};
			"LFT": r = {1'b1, 8'h5B};
			"RGH": r = {1'b1, 8'h5C};
			"ROU": r = {1'b1, 8'h5D};
			"MOD": r = {1'b1, 8'h5E};
			"DEG": r = {1'b1, 8'h60};
			"GTO": r = {1'b1, 8'h61};
			"PG*": r = {1'b1, 8'h62};
			"EX*": r = {1'b1, 8'h63};
			"PD*": r = {1'b1, 8'h64};
			k1("*"): r = {1'b1, 8'h65};
			"PAU": r = {1'b1, 8'h66};
			k2("EQ"): r = {1'b1, 8'h67};
			"NOP": r = {1'b1, 8'h68};
			k2("OP"): r = {1'b1, 8'h69};
			"REL": r = {1'b1, 8'h6A};
			"IN*": r = {1'b1, 8'h6B};
			"RE*": r = {1'b1, 8'h6C};
			"IF*": r = {1'b1, 8'h6D};
			"AND": r = {1'b1, 8'h6E};
			"RAD": r = {1'b1, 8'h70};
			"SBR": r = {1'b1, 8'h71};
			"ST*": r = {1'b1, 8'h72};
			"RC*": r = {1'b1, 8'h73};
			"SM*": r = {1'b1, 8'h74};
			k1("-"): r = {1'b1, 8'h75};
			"LBL": r = {1'b1, 8'h76};
			k2("GE"): r = {1'b1, 8'h77};
			"STA": r = {1'b1, 8'h78};
			"AVR": r = {1'b1, 8'h79};
			k2("IF"): r = {1'b1, 8'h7A};
			"XOR": r = {1'b1, 8'h7E};
			"GRD": r = {1'b1, 8'h80};
			"RST": r = {1'b1, 8'h81};
			"HIR": r = {1'b1, 8'h82};
			"GO*": r = {1'b1, 8'h83};
			"OP*": r = {1'b1, 8'h84};
			k1("+"): r = {1'b1, 8'h85};
			"STF": r = {1'b1, 8'h86};
			"IFF": r = {1'b1, 8'h87};
			"DMS": r = {1'b1, 8'h88};
			k2("PI"): r = {1'b1, 8'h89};
			"REG": r = {1'b1, 8'h8A};
			"HEX": r = {1'b1, 8'h8B};
			"BIN": r = {1'b1, 8'h8C};
			"OCT": r = {1'b1, 8'h8D};
			k2("OR"): r = {1'b1, 8'h8E};
			"LST": r = {1'b1, 8'h90};
			"R/S": r = {1'b1, 8'h91};
			"RTN": r = {1'b1, 8'h92};
			k1("."): r = {1'b1, 8'h93};
			"+/-": r = {1'b1, 8'h94};
			k1("="): r = {1'b1, 8'h95};
			"WRT": r = {1'b1, 8'h96};
			"DSZ": r = {1'b1, 8'h97};
			"ADV": r = {1'b1, 8'h98};
			"PRT": r = {1'b1, 8'h99};
			"PHI": r = {1'b1, 8'h9A};
			"DEC": r = {1'b1, 8'h9B};
			"INC": r = {1'b1, 8'h9C};
			"NOT": r = {1'b1, 8'h9D};
			k1("%"): r = {1'b1, 8'h9E};
			"...": r = {1'b1, 8'hFF};
			default: r = 9'h000;
		endcase
		return r;
	endfunction

endpackage

### sv/mtto_front.sv
module mtto_front import mtto_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] char_in,
	input  logic       is_last,
	output logic       push,
	output tok_t       push_tok
);

	logic [23:0] text_q;
	logic [2:0]  len_q;
	logic        comment_q;
	logic [7:0]  c;
	logic        white;
	logic [23:0] p_text;
	logic [2:0]  p_len;
	logic        p_comment;
	logic        emit;

	always_comb begin
		c = char_in;
		if (c >= CH_LA && c <= CH_LZ) c = c - CASE_OFS;
		white = (c <= CH_SPACE);
		p_text = text_q;
		p_len = len_q;
		p_comment = comment_q;
		if (comment_q) begin
			if (c == CH_LF) p_comment = 1'b0;
		end else if (!white) begin
			if (len_q == 3'd0 && c == CH_SEMI) begin
				p_comment = 1'b1;
			end else begin
				if (len_q < 3'd3) p_text[len_q[1:0]*8 +: 8] = c;
				if (len_q < 3'd4) p_len = len_q + 3'd1;
			end
		end
		// whitespace leaves text untouched, so p_* is the token in both cases
		emit = (!comment_q && white && len_q != 3'd0) || (is_last && p_len != 3'd0);
	end

	assign push = take && emit;
	assign push_tok = '{text: p_text, len: p_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q <= '0;
			len_q <= '0;
			comment_q <= 1'b0;
		end else if (take) begin
			if (emit || is_last) begin
				text_q <= '0;
				len_q <= '0;
			end else begin
				text_q <= p_text;
				len_q <= p_len;
			end
			comment_q <= p_comment && !is_last;
		end
	end

endmodule

### sv/mtto_fifo.sv
module mtto_fifo import mtto_pkg::*; #(
	parameter int Depth = QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	input  logic pop,
	output logic not_full,
	output logic not_empty,
	output tok_t head
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	tok_t          mem_q [Depth];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign not_full = cnt_q != CW'(Depth);
	assign not_empty = cnt_q != '0;
	assign head = mem_q[rd_q];

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop) rd_q <= nxt(rd_q);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

### sv/mtto_back.sv
module mtto_back import mtto_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  tok_t        tok,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  code_byte,
	output logic        unknown_token,
	output logic [15:0] running_sum
);

	logic [7:0]  c0, c1, c2;
	logic [8:0]  hit;
	logic        known;
	logic [7:0]  code;
	logic        valid_q;
	logic [7:0]  code_q;
	logic        unk_q;
	logic [15:0] sum_q;
	logic        load;

	always_comb begin
		c0 = tok.text[7:0];
		c1 = tok.text[15:8];
		c2 = tok.text[23:16];
		if (c0 == "W" && c1 == "R" && c2 == "I") c2 = "T";
		if (c0 == "G" && c1 == "T" && c2 == "*") c1 = "O";
		hit = lookup({c0, c1, c2});
		known = 1'b0;
		code = 8'h00;
		if (tok.len <= 3'd3) begin
			if (hit[8]) begin
				known = 1'b1;
				code = hit[7:0];
			end else if (tok.len == 3'd2 && c0 >= "0" && c0 <= "9" && is_hex(c1)) begin
				known = 1'b1;
				code = {c0[3:0], hex_val(c1)};
			end else if (tok.len == 3'd3 && c0 == "0" && is_hex(c1) && is_hex(c2)) begin
				known = 1'b1;
				code = {hex_val(c1), hex_val(c2)};
			end
		end
	end

	assign load = tok_valid && (!valid_q || out_ready);
	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sum_q <= '0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (load && known) sum_q <= sum_q + {8'h00, code};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= code;
			unk_q <= !known;
		end
	end

	assign out_valid = valid_q;
	assign code_byte = code_q;
	assign unknown_token = unk_q;
	assign running_sum = sum_q;

	a_unk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && unk_q |-> code_q == 8'h00)
		else $error("unknown token with nonzero code");
	a_unk_sum: assert property (@(posedge clk) disable iff (!arst_n)
		load && !known |=> sum_q == $past(sum_q))
		else $error("sum moved on unknown token");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not presented");

endmodule

### sv/mnemonic_token_to_opcode.sv
// Mnemonic token to code converter.
// Input channel: one source byte per request (char_in, is_last) on
// in_valid/in_ready. Letters fold to upper case, bytes up to 32 separate
// tokens, ';' at token start opens a comment up to line feed.
// Output channel: one request per finished token (code_byte, unknown_token,
// running_sum) on out_valid/out_ready; running_sum includes this code.
// Throughput: one byte per cycle while in_ready is high. The front end
// classifies bytes and builds tokens, a small token queue (QueueDepth
// entries) feeds the back end, which does the table match and sum update
// into an output register.
// A token is written into the queue when the byte that ends it (whitespace
// or is_last) is accepted, and its result is registered when it is popped.
// Reset clears the token, comment flag, running sum and queue.
// When the receiver stalls, the output register holds, the queue fills and
// in_ready drops once the queue is full.
module mnemonic_token_to_opcode import mtto_pkg::*; #(
	parameter int QueueDepth = QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  code_byte,
	output logic        unknown_token,
	output logic [15:0] running_sum
);

	logic take, push, pop, not_full, not_empty;
	tok_t push_tok, head;

	assign in_ready = not_full;
	assign take = in_valid && in_ready;

	mtto_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .char_in(char_in),
		.is_last(is_last), .push(push), .push_tok(push_tok)
	);

	mtto_fifo #(.Depth(QueueDepth)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_tok(push_tok), .pop(pop),
		.not_full(not_full), .not_empty(not_empty), .head(head)
	);

	mtto_back u_back (
		.clk(clk), .arst_n(arst_n), .tok_valid(not_empty), .tok(head), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .code_byte(code_byte),
		.unknown_token(unknown_token), .running_sum(running_sum)
	);

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import mtto_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} src_byte_t;

	typedef struct {
		logic [7:0]  code;
		logic        unk;
		logic [15:0] sum;
	} code_res_t;

	localparam int CycleLimit = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_in = 8'd32;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  code_byte;
	logic        unknown_token;
	logic [15:0] running_sum;

	mnemonic_token_to_opcode u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.char_in(char_in), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.code_byte(code_byte), .unknown_token(unknown_token),
		.running_sum(running_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	string       mnem_tab [256];
	src_byte_t   pending_bytes [$];
	code_res_t   expected_codes [$];
	int          errors = 0;
	int          cycles = 0;
	int          sent = 0;
	int          pause_at = -1;
	bit          long_stall_req = 0;

	// first 160 table entries; the rest are empty except the last
	string mnem_lst [160] = '{
		"0","1","2","3","4","5","6","7","8","9","0A","0B","0C","0D","0E","0F",
		"E'","A","B","C","D","E","A'","B'","C'","D'","A''","B''","C''","D''","E''","F",
		"","2ND","INV","LNX","CE","CLR","SB*","HI*","LOG","CP","","COD","LG2","RND","","",
		"TAN","LRN","X/T","X2","SQR","1/X","PGM","P/R","SIN","COS","TMP","X/Y","SNH",
		"CSH","TNH","",
		"IND","SST","STO","RCL","SUM","YX","INS","CMS","EXC","PRD","BAT","N!","LN!","LG!",
		"MD2","",
		"IXI","BST","EE","(",")","/","DEL","ENG","FIX","INT","LCD","LFT","RGH","ROU",
		"MOD","",
		"DEG","GTO","PG*","EX*","PD*","*","PAU","EQ","NOP","OP","REL","IN*","RE*","IF*",
		"AND","",
		"RAD","SBR","ST*","RC*","SM*","-","LBL","GE","STA","AVR","IF","","","","XOR","",
		"GRD","RST","HIR","GO*","OP*","+","STF","IFF","DMS","PI","REG","HEX","BIN","OCT",
		"OR","",
		"LST","R/S","RTN",".","+/-","=","WRT","DSZ","ADV","PRT","PHI","DEC","INC","NOT",
		"%",""
	};

	// predictor state
	logic [23:0] tok_text = '0;
	logic [2:0]  tok_len = '0;
	logic        in_cmt = 1'b0;
	logic [15:0] code_sum = '0;

	function automatic bit hexd(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hexv(logic [7:0] c);
		return (c <= "9") ? 4'(c - "0") : 4'(c - "A" + 10);
	endfunction

	// match the gathered token; returns {known, code}
	function automatic logic [8:0] match_token(logic [23:0] txt, logic [2:0] len);
		logic [7:0] c [3];
		logic [7:0] ev, tv;
		bit ok;
		if (len > 3 || len == 0) return 9'h000;
		for (int k = 0; k < 3; k++) c[k] = (k < len) ? txt[8*k +: 8] : 8'h00;
		if (c[0] == "W" && c[1] == "R" && c[2] == "I") c[2] = "T";
		if (c[0] == "G" && c[1] == "T" && c[2] == "*") c[1] = "O";
		for (int j = 0; j < 256; j++) begin
			ok = 1;
			for (int k = 0; k < 4; k++) begin
				ev = (k < mnem_tab[j].len()) ? mnem_tab[j][k] : 8'h00;
				tv = (k < len) ? c[k] : 8'h00;
				if (ev != tv) begin
					ok = 0;
					break;
				end
				if (ev == 0) break;
			end
			if (ok) return {1'b1, 8'(j)};
		end
		if (len == 2 && c[0] >= "0" && c[0] <= "9" && hexd(c[1]))
			return {1'b1, 4'(c[0] - "0"), hexv(c[1])};
		if (len == 3 && c[0] == "0" && hexd(c[1]) && hexd(c[2]))
			return {1'b1, hexv(c[1]), hexv(c[2])};
		return 9'h000;
	endfunction

	task automatic close_token();
		logic [8:0] m;
		code_res_t r;
		m = match_token(tok_text, tok_len);
		if (m[8]) code_sum = code_sum + m[7:0];
		r.code = m[8] ? m[7:0] : 8'h00;
		r.unk = !m[8];
		r.sum = code_sum;
		expected_codes.push_back(r);
		tok_text = '0;
		tok_len = '0;
	endtask

	task automatic predict_byte(logic [7:0] ch_raw, logic last);
		logic [7:0] c;
		bit emitted;
		emitted = 0;
		c = (ch_raw >= "a" && ch_raw <= "z") ? ch_raw - 8'd32 : ch_raw;
		if (in_cmt) begin
			if (c == 8'd10) in_cmt = 1'b0;
		end else if (c <= 8'd32) begin
			if (tok_len > 0) begin
				close_token();
				emitted = 1;
			end
		end else if (tok_len == 0 && c == ";") begin
			in_cmt = 1'b1;
		end else begin
			if (tok_len < 3) tok_text[8*tok_len +: 8] = c;
			if (tok_len < 4) tok_len++;
		end
		if (last) begin
			if (!emitted && tok_len > 0) close_token();
			tok_text = '0;
			tok_len = '0;
			in_cmt = 1'b0;
		end
	endtask

	task automatic push_text(string s, bit last_end);
		src_byte_t b;
		for (int i = 0; i < s.len(); i++) begin
			b.ch = s[i];
			b.last = last_end && (i == s.len() - 1);
			pending_bytes.push_back(b);
		end
	endtask

	task automatic push_raw(logic [7:0] ch, logic last);
		src_byte_t b;
		b.ch = ch;
		b.last = last;
		pending_bytes.push_back(b);
	endtask

	function automatic string rand_case(string s);
		string t;
		t = s;
		for (int i = 0; i < t.len(); i++)
			if (t[i] >= "A" && t[i] <= "Z" && $urandom_range(0, 1)) t[i] = t[i] + 8'd32;
		return t;
	endfunction

	task automatic push_sep();
		case ($urandom_range(0, 5))
			0: push_raw(8'd0, 1'b0);
			1: push_raw(8'(9 + $urandom_range(0, 4)), 1'b0);
			2: push_raw(8'($urandom_range(1, 32)), 1'b0);
			default: push_raw(8'd32, 1'b0);
		endcase
	endtask

	// one random token, properly formed most of the time
	task automatic push_rand_token();
		string s;
		int j;
		s = "";
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				do j = $urandom_range(0, 255); while (mnem_tab[j].len() == 0);
				s = rand_case(mnem_tab[j]);
			end
			4: s = $sformatf("%0d%1h", $urandom_range(0, 9), $urandom_range(0, 15));
			5: s = $sformatf("0%02h", $urandom_range(0, 255));
			6: s = rand_case($urandom_range(0, 1) ? "WRI" : "GT*");
			7: begin
				s = ";";
				repeat ($urandom_range(0, 6)) s = {s, string'(8'($urandom_range(33, 126)))};
				s = {s, "\n"};
			end
			default: begin
				repeat ($urandom_range(1, 5)) s = {s, string'(8'($urandom_range(33, 255)))};
			end
		endcase
		if ($urandom_range(0, 19) == 0) begin
			push_text(s, 1'b1);
		end else begin
			push_text(s, 1'b0);
			push_sep();
		end
	endtask

	// driver: bursts and gaps on the request side
	int  gap_left = 0;
	int  burst_left = 4;
	bit  in_taken = 0;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() > 0 &&
				!(sent == pause_at && expected_codes.size() > 0)) begin
				char_in <= pending_bytes[0].ch;
				is_last <= pending_bytes[0].last;
				void'(pending_bytes.pop_front());
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	int stall_cnt = 0;
	int ready_phase = 0;
	always @(negedge clk) begin
		if (long_stall_req && stall_cnt == 0) begin
			stall_cnt <= 300;
			long_stall_req <= 0;
			out_ready <= 1'b0;
		end else if (stall_cnt > 1) begin
			stall_cnt <= stall_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			stall_cnt <= 0;
			ready_phase <= ready_phase + 1;
			if (ready_phase % 200 < 60) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		code_res_t e;
		cycles <= cycles + 1;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			predict_byte(char_in, is_last);
			sent <= sent + 1;
			if (sent == 600) long_stall_req <= 1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected result code=%h unk=%b sum=%h", $time,
					code_byte, unknown_token, running_sum);
				errors++;
			end else begin
				e = expected_codes.pop_front();
				if (code_byte !== e.code) begin
					$display("%0t: code_byte exp %h got %h", $time, e.code, code_byte);
					errors++;
				end
				if (unknown_token !== e.unk) begin
					$display("%0t: unknown_token exp %b got %b", $time, e.unk,
						unknown_token);
					errors++;
				end
				if (running_sum !== e.sum) begin
					$display("%0t: running_sum exp %h got %h", $time, e.sum, running_sum);
					errors++;
				end
			end
		end
		if (cycles >= CycleLimit) begin
			$display("mnemonic_token_to_opcode regression: fail");
			$finish;
		end
	end

	initial begin
		for (int j = 0; j < 256; j++) mnem_tab[j] = (j < 160) ? mnem_lst[j] : "";
		mnem_tab[255] = "...";

		// directed part
		push_text("sto wri gt* 2nd ", 1'b0);
		push_text("9f 0ff 00 0a0 ", 1'b0);
		push_text("abcd", 1'b0);
		push_raw(8'd0, 1'b0);
		push_raw(8'd255, 1'b0);
		push_raw(8'd128, 1'b0);
		push_raw(8'd32, 1'b0);
		push_text("a;b ;skip it\nrcl", 1'b0);
		push_raw(8'd10, 1'b0);
		push_text("...\t;open", 1'b1);
		push_text("lbl", 1'b1);
		push_text("zz ", 1'b0);
		push_raw(8'd200, 1'b1);

		while (pending_bytes.size() < 1100) push_rand_token();
		pause_at = 900;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (pending_bytes.size() == 0 && !in_valid);
		wait (expected_codes.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_codes.size() == 0)
			$display("mnemonic_token_to_opcode regression: pass");
		else
			$display("mnemonic_token_to_opcode regression: fail");
		$finish;
	end

endmodule

### filelist.f
sv/mtto_pkg.sv
sv/mtto_front.sv
sv/mtto_fifo.sv
sv/mtto_back.sv
sv/mnemonic_token_to_opcode.sv
sim/testbench.sv
